// ===== hw/rtl/bses_pkg.sv =====
package bses_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned SumW  = 48;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_PV_SIZE        = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CAPACITY       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CHARGE_GAIN    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DISCHARGE_GAIN = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_UPPER_SLOPE    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_LOWER_SLOPE    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_ENERGY = 3'd6;

  typedef struct packed {
    logic [DataW-1:0] pv_size;
    logic [DataW-1:0] capacity;
    logic [DataW-1:0] charge_gain;
    logic [DataW-1:0] discharge_gain;
    logic [DataW-1:0] upper_limit_slope;
    logic [DataW-1:0] lower_limit_slope;
    logic [DataW-1:0] initial_energy;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic gen;
    logic req;
    logic div;
    logic init;
    logic search;
    logic apply;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic exhausted;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/bses_if.sv =====
interface bses_in_if;
  logic        valid;
  logic        ready;
  logic        start_run;
  logic [31:0] load_power;
  logic [31:0] solar_power;

  modport source (output valid, start_run, load_power, solar_power, input ready);
  modport sink (input valid, start_run, load_power, solar_power, output ready);
endinterface

interface bses_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] energy_after;
  logic [31:0] charge_applied;
  logic [31:0] discharge_applied;
  logic        loss_flag;
  logic [31:0] loss_count;
  logic [47:0] deficit_total;
  logic [47:0] load_total;

  modport source (output valid, energy_after, charge_applied, discharge_applied, loss_flag,
                  loss_count, deficit_total, load_total, input ready);
  modport sink (input valid, energy_after, charge_applied, discharge_applied, loss_flag,
                loss_count, deficit_total, load_total, output ready);
endinterface

// ===== hw/rtl/bses_ctrl.sv =====
module bses_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bses_pkg::sts_t  sts_i,
  output bses_pkg::cmd_t  cmd_o
);
  import bses_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_GEN    = 3'd1;
  localparam logic [2:0] ST_REQ    = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_FIX    = 3'd4;
  localparam logic [2:0] ST_SEARCH = 3'd5;
  localparam logic [2:0] ST_APPLY  = 3'd6;
  localparam logic [2:0] ST_UPDATE = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_GEN;
      ST_GEN:    state_d = ST_REQ;
      ST_REQ:    state_d = ST_DIV;
      ST_DIV:    state_d = ST_FIX;
      ST_FIX:    state_d = ST_SEARCH;
      ST_SEARCH: if (sts_i.found || sts_i.exhausted) state_d = ST_APPLY;
      ST_APPLY:  state_d = ST_UPDATE;
      ST_UPDATE: if (sts_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.gen     = (state_q == ST_GEN);
    cmd_o.req     = (state_q == ST_REQ);
    cmd_o.div     = (state_q == ST_DIV);
    cmd_o.init    = (state_q == ST_FIX);
    cmd_o.search  = (state_q == ST_SEARCH);
    cmd_o.apply   = (state_q == ST_APPLY);
    cmd_o.commit  = (state_q == ST_UPDATE) && sts_i.out_free;
  end

endmodule

// ===== hw/rtl/bses_dp.sv =====
module bses_dp #(
  parameter int unsigned GridSteps = 30,
  parameter int unsigned FracBits  = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bses_pkg::cfg_t            cfg_i,
  input  bses_pkg::cmd_t            cmd_i,
  output bses_pkg::sts_t            sts_o,
  input  logic                      start_i,
  input  logic [bses_pkg::DataW-1:0] load_i,
  input  logic [bses_pkg::DataW-1:0] solar_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [bses_pkg::DataW-1:0] energy_o,
  output logic [bses_pkg::DataW-1:0] charge_o,
  output logic [bses_pkg::DataW-1:0] discharge_o,
  output logic                      loss_o,
  output logic [bses_pkg::DataW-1:0] loss_count_o,
  output logic [bses_pkg::SumW-1:0]  deficit_o,
  output logic [bses_pkg::SumW-1:0]  load_total_o
);
  import bses_pkg::*;

  localparam int unsigned DivShift = $clog2(GridSteps);
  localparam int unsigned PreShift = DataW + DivShift;
  localparam logic [DataW:0] DivMagic =
    (DataW+1)'(((65'd1 << PreShift) / GridSteps) + 65'd1);
  localparam int unsigned RemW = DivShift;
  localparam int unsigned CntW = $clog2(GridSteps + 1);
  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned ChgW = ProdW - FracBits;
  localparam int unsigned CmpW = ProdW + 2;

  // request capture and generation
  logic [DataW-1:0] load_q, solar_q, gen_q, req_q, qest_q;
  logic             dis_q;
  logic [ProdW-1:0] gprod, gshift;
  logic [2*DataW:0] dprod;
  logic [DataW+7:0] rfull;

  // grid search
  logic [DataW-1:0] qp_q, cand_q, tval_q;
  logic [RemW-1:0]  rp_q, rem_q;
  logic [RemW+1:0]  rwrap;
  logic [CntW-1:0]  cnt_q;
  logic             issue_q, tv_q, tlast_q;
  logic [ProdW-1:0] prodg_q;
  logic signed [ProdW-1:0] prods_q;
  logic [DataW-1:0] gain_sel, slope_sel;
  logic signed [CmpW-1:0] b_s, ch_s, lim_s, cap_s, chg_s, nb_s;
  logic             fit, found, exhausted;

  // update
  logic [DataW-1:0] applied_q;
  logic [ChgW-1:0]  chg_q;
  logic [ProdW-1:0] aprod;
  logic [DataW-1:0] bat_q, lcnt_q, nb_sat;
  logic [SumW-1:0]  dsum_q, lsum_q, lbase;
  logic [SumW:0]    lsum_add, dsum_add;
  logic             loss;
  logic             out_valid_q;

  assign gain_sel  = dis_q ? cfg_i.discharge_gain : cfg_i.charge_gain;
  assign slope_sel = dis_q ? cfg_i.lower_limit_slope : cfg_i.upper_limit_slope;

  assign gprod  = ProdW'(solar_q) * ProdW'(cfg_i.pv_size);
  assign gshift = gprod >> FracBits;
  assign dprod  = (2*DataW+1)'(req_q) * (2*DataW+1)'(DivMagic);
  assign rfull  = (DataW+8)'(req_q) - (DataW+8)'(qest_q) * (DataW+8)'(GridSteps);
  assign rwrap  = (RemW+2)'(rem_q) + (RemW+2)'(GridSteps) - (RemW+2)'(rp_q);

  assign lbase    = start_i ? '0 : lsum_q;
  assign lsum_add = (SumW+1)'(lbase) + (SumW+1)'(load_i);

  // fit test on registered products
  assign b_s   = $signed(CmpW'(bat_q));
  assign ch_s  = $signed(CmpW'(prodg_q >> FracBits));
  assign cap_s = $signed(CmpW'(cfg_i.capacity));
  assign lim_s = CmpW'(prods_q >>> FracBits);
  assign fit   = dis_q ? (b_s - ch_s >= lim_s) : (b_s + ch_s <= lim_s + cap_s);

  assign found     = cmd_i.search && tv_q && fit;
  assign exhausted = cmd_i.search && tv_q && !fit && tlast_q;

  assign aprod  = ProdW'(applied_q) * ProdW'(gain_sel);
  assign chg_s  = $signed(CmpW'(chg_q));
  assign nb_s   = dis_q ? (b_s - chg_s) : (b_s + chg_s);
  assign nb_sat = nb_s[CmpW-1] ? '0 :
                  (|nb_s[CmpW-2:DataW]) ? '1 : nb_s[DataW-1:0];
  assign loss     = dis_q && (applied_q < req_q);
  assign dsum_add = (SumW+1)'(dsum_q) + (SumW+1)'(req_q - applied_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      load_q  <= load_i;
      solar_q <= solar_i;
    end
    if (cmd_i.gen) begin
      gen_q <= (|gshift[ProdW-1:DataW]) ? '1 : gshift[DataW-1:0];
    end
    if (cmd_i.req) begin
      dis_q <= !(gen_q > load_q);
      req_q <= (gen_q > load_q) ? gen_q - load_q : load_q - gen_q;
    end
    if (cmd_i.div) begin
      qest_q <= DataW'(dprod >> PreShift);
    end
    if (cmd_i.init) begin
      if (rfull >= (DataW+8)'(GridSteps)) begin
        qp_q <= qest_q + 1'b1;
        rp_q <= RemW'(rfull - (DataW+8)'(GridSteps));
      end else begin
        qp_q <= qest_q;
        rp_q <= RemW'(rfull);
      end
      cand_q <= req_q;
      rem_q  <= '0;
      cnt_q  <= CntW'(GridSteps);
    end else if (cmd_i.search && issue_q) begin
      tval_q  <= cand_q;
      tlast_q <= (cnt_q == '0);
      prodg_q <= ProdW'(cand_q) * ProdW'(gain_sel);
      prods_q <= ProdW'($signed(slope_sel) * $signed({1'b0, cand_q}));
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (rem_q >= rp_q) begin
          rem_q  <= rem_q - rp_q;
          cand_q <= cand_q - qp_q;
        end else begin
          rem_q  <= RemW'(rwrap);
          cand_q <= cand_q - qp_q - 1'b1;
        end
      end
    end
    if (found || exhausted) begin
      applied_q <= !found ? '0 : (tval_q > cfg_i.capacity) ? cfg_i.capacity : tval_q;
    end
    if (cmd_i.apply) begin
      chg_q <= ChgW'(aprod >> FracBits);
    end
    if (cmd_i.commit) begin
      energy_o     <= nb_sat;
      charge_o     <= dis_q ? '0 : applied_q;
      discharge_o  <= dis_q ? applied_q : '0;
      loss_o       <= loss;
      loss_count_o <= (loss && lcnt_q != '1) ? lcnt_q + 1'b1 : lcnt_q;
      deficit_o    <= !loss ? dsum_q : dsum_add[SumW] ? '1 : dsum_add[SumW-1:0];
      load_total_o <= lsum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q     <= 1'b0;
      tv_q        <= 1'b0;
      bat_q       <= '0;
      lcnt_q      <= '0;
      dsum_q      <= '0;
      lsum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.init) begin
        issue_q <= 1'b1;
        tv_q    <= 1'b0;
      end else if (cmd_i.search) begin
        tv_q <= issue_q;
        if (issue_q && cnt_q == '0) issue_q <= 1'b0;
      end
      if (cmd_i.capture) begin
        if (start_i) begin
          bat_q  <= cfg_i.initial_energy;
          lcnt_q <= '0;
          dsum_q <= '0;
        end
        lsum_q <= lsum_add[SumW] ? '1 : lsum_add[SumW-1:0];
      end
      if (cmd_i.commit) begin
        bat_q <= nb_sat;
        if (loss) begin
          if (lcnt_q != '1) lcnt_q <= lcnt_q + 1'b1;
          dsum_q <= dsum_add[SumW] ? '1 : dsum_add[SumW-1:0];
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.found     = found;
  assign sts_o.exhausted = exhausted;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ===== hw/rtl/battery_solar_energy_step_top.sv =====
// The grid search tests one candidate per cycle through a multiply stage
// followed by a compare stage, and stops at the first fit or when the grid
// runs out. One request is in flight: a new request is not accepted until
// the previous one has posted its result.
// Reset: battery energy, loss count and totals clear to zero; registers take
// their defaults (pv_size and both gains 1.0, all others zero).
module battery_solar_energy_step_top #(
  parameter int unsigned GridSteps = 30,
  parameter int unsigned FracBits  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bses_in_if.sink                        in_ch,
  bses_out_if.source                     out_ch,
  input  logic                           cfg_we_i,
  input  logic [bses_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bses_pkg::DataW-1:0]     cfg_data_i
);
  import bses_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pv_size           <= DataW'(1) << FracBits;
      cfg_q.capacity          <= '0;
      cfg_q.charge_gain       <= DataW'(1) << FracBits;
      cfg_q.discharge_gain    <= DataW'(1) << FracBits;
      cfg_q.upper_limit_slope <= '0;
      cfg_q.lower_limit_slope <= '0;
      cfg_q.initial_energy    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PV_SIZE:        cfg_q.pv_size           <= cfg_data_i;
        CFG_CAPACITY:       cfg_q.capacity          <= cfg_data_i;
        CFG_CHARGE_GAIN:    cfg_q.charge_gain       <= cfg_data_i;
        CFG_DISCHARGE_GAIN: cfg_q.discharge_gain    <= cfg_data_i;
        CFG_UPPER_SLOPE:    cfg_q.upper_limit_slope <= cfg_data_i;
        CFG_LOWER_SLOPE:    cfg_q.lower_limit_slope <= cfg_data_i;
        CFG_INITIAL_ENERGY: cfg_q.initial_energy    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bses_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bses_dp #(
    .GridSteps (GridSteps),
    .FracBits  (FracBits)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .start_i      (in_ch.start_run),
    .load_i       (in_ch.load_power),
    .solar_i      (in_ch.solar_power),
    .out_valid_o  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .energy_o     (out_ch.energy_after),
    .charge_o     (out_ch.charge_applied),
    .discharge_o  (out_ch.discharge_applied),
    .loss_o       (out_ch.loss_flag),
    .loss_count_o (out_ch.loss_count),
    .deficit_o    (out_ch.deficit_total),
    .load_total_o (out_ch.load_total)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while another is in flight");

  a_result_ends_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_ch.valid && in_ch.ready)
    else $error("result posted without returning to idle");

  a_one_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> out_ch.charge_applied == '0 || out_ch.discharge_applied == '0)
    else $error("charge and discharge both nonzero");

  a_loss_discharge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.loss_flag |-> out_ch.charge_applied == '0)
    else $error("loss reported on a charging step");

endmodule
